[src/rpse_pkg.sv]
package rpse_pkg;

    localparam int INDEX_ENTRIES = 64;
    localparam int SLOT_W        = $clog2(INDEX_ENTRIES);
    localparam int RUN_W         = 6;
    localparam int MAX_BYTES     = 5;
    localparam int COUNT_W       = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [RUN_W-1:0] RUN_LIMIT = 6'd62;

    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;
    localparam logic [7:0] OP_RGB   = 8'hFE;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_cmd;

endpackage

[src/rpse_if.sv]
interface rpse_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rpse_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       image_done;

    modport source (output valid, code_byte, last_of_item, image_done, input ready);
    modport sink   (input valid, code_byte, last_of_item, image_done, output ready);
endinterface

[src/rpse_front.sv]
module rpse_front import rpse_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rpse_pix_if.sink     i_pix,
    input  logic         i_q_ready,
    output logic         o_push,
    output t_cmd         o_cmd
);

    // stage 1: accepted pixel, slot and registered index read
    logic                r_s1_valid;
    logic [23:0]         r_s1_pix;
    logic                r_s1_last;
    logic [SLOT_W-1:0]   r_s1_slot;
    logic [23:0]         r_rd_data;

    // encoder state
    logic [23:0]              r_prev;
    logic [RUN_W-1:0]         r_run;
    logic                     r_seen;
    logic [INDEX_ENTRIES-1:0] r_valid;
    logic [23:0]              r_index [INDEX_ENTRIES];
    logic                     r_fwd_ok;
    logic [SLOT_W-1:0]        r_fwd_slot;
    logic [23:0]              r_fwd_pix;

    logic              accept;
    logic              s2_fire;
    logic [11:0]       slot_sum;
    logic [SLOT_W-1:0] n_slot;

    logic [7:0]        cr, cg, cb;
    logic signed [7:0] dr, dg, db;
    logic [7:0]        t_dr, t_dg, t_db, t_lr, t_lg, t_lb;
    logic              same, run_ext, run_pend;
    logic [23:0]       entry;
    logic              hit, is_diff, is_luma;
    logic [3:0][7:0]   code;
    logic [COUNT_W-1:0] code_n;
    logic [RUN_W-1:0]  run_m1;
    logic              idx_we;
    t_cmd              cmd;

    assign accept      = i_pix.valid && i_pix.ready;
    assign s2_fire     = r_s1_valid && i_q_ready;
    assign i_pix.ready = !r_s1_valid || s2_fire;

    assign slot_sum = 12'd3 * {4'd0, i_pix.red} + 12'd5 * {4'd0, i_pix.green}
                    + 12'd7 * {4'd0, i_pix.blue};
    assign n_slot   = slot_sum[SLOT_W-1:0];

    assign cr = r_s1_pix[23:16];
    assign cg = r_s1_pix[15:8];
    assign cb = r_s1_pix[7:0];
    assign dr = cr - r_prev[23:16];
    assign dg = cg - r_prev[15:8];
    assign db = cb - r_prev[7:0];

    assign t_dr = dr + 8'd2;
    assign t_dg = dg + 8'd2;
    assign t_db = db + 8'd2;
    assign t_lr = dr + 8'd8;
    assign t_lg = dg + 8'd32;
    assign t_lb = db + 8'd8;

    assign same     = r_seen && (r_s1_pix == r_prev);
    assign run_ext  = same && (r_run < RUN_LIMIT);
    assign run_pend = (r_run != '0);
    assign run_m1   = r_run - 1'b1;

    // unwritten entries read as zero
    always_comb begin
        if (!r_valid[r_s1_slot]) begin
            entry = '0;
        end else if (r_fwd_ok && (r_fwd_slot == r_s1_slot)) begin
            entry = r_fwd_pix;
        end else begin
            entry = r_rd_data;
        end
    end

    assign hit = (entry == r_s1_pix);

    assign is_diff = r_seen
                   && dr >= -8'sd2 && dr <= 8'sd1
                   && dg >= -8'sd2 && dg <= 8'sd1
                   && db >= -8'sd2 && db <= 8'sd1;
    assign is_luma = r_seen
                   && dg >= -8'sd32 && dg <= 8'sd31
                   && dr >= -8'sd8 && dr <= 8'sd7
                   && db >= -8'sd8 && db <= 8'sd7;

    always_comb begin
        code = '0;
        if (hit) begin
            code[0] = OP_INDEX | {2'b00, r_s1_slot};
            code_n  = 3'd1;
        end else if (is_diff) begin
            code[0] = OP_DIFF | {2'b00, t_dr[1:0], t_dg[1:0], t_db[1:0]};
            code_n  = 3'd1;
        end else if (is_luma) begin
            code[0] = OP_LUMA | {2'b00, t_lg[5:0]};
            code[1] = {t_lr[3:0], t_lb[3:0]};
            code_n  = 3'd2;
        end else begin
            code[0] = OP_RGB;
            code[1] = cr;
            code[2] = cg;
            code[3] = cb;
            code_n  = 3'd4;
        end
    end

    always_comb begin
        cmd       = '0;
        cmd.last  = r_s1_last;
        if (run_ext) begin
            cmd.bytes[0] = OP_RUN | {2'b00, r_run};
            cmd.count    = r_s1_last ? 3'd1 : 3'd0;
        end else if (run_pend) begin
            cmd.bytes[0] = OP_RUN | {2'b00, run_m1};
            cmd.bytes[1] = code[0];
            cmd.bytes[2] = code[1];
            cmd.bytes[3] = code[2];
            cmd.bytes[4] = code[3];
            cmd.count    = code_n + 3'd1;
        end else begin
            cmd.bytes[0] = code[0];
            cmd.bytes[1] = code[1];
            cmd.bytes[2] = code[2];
            cmd.bytes[3] = code[3];
            cmd.count    = code_n;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = s2_fire && (cmd.count != '0);
    assign idx_we = s2_fire && !run_ext && !hit && !r_s1_last;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_index[n_slot];
        end
        if (idx_we) begin
            r_index[r_s1_slot] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= {i_pix.red, i_pix.green, i_pix.blue};
            r_s1_last <= i_pix.last_pixel;
            r_s1_slot <= n_slot;
        end
        if (s2_fire && !run_ext) begin
            r_prev <= r_s1_pix;
        end
        if (idx_we) begin
            r_fwd_slot <= r_s1_slot;
            r_fwd_pix  <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_run      <= '0;
            r_seen     <= 1'b0;
            r_valid    <= '0;
            r_fwd_ok   <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_fire) begin
                if (r_s1_last) begin
                    r_run    <= '0;
                    r_seen   <= 1'b0;
                    r_valid  <= '0;
                    r_fwd_ok <= 1'b0;
                end else if (run_ext) begin
                    r_run <= r_run + 1'b1;
                end else begin
                    r_run  <= '0;
                    r_seen <= 1'b1;
                    if (!hit) begin
                        r_valid[r_s1_slot] <= 1'b1;
                        r_fwd_ok           <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

[src/rpse_queue.sv]
module rpse_queue import rpse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_fill;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_fill != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

[src/rpse_back.sv]
module rpse_back import rpse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    rpse_code_if.source o_code
);

    logic               r_out_valid;
    logic [7:0]         r_byte;
    logic               r_last_item;
    logic               r_done;
    logic [COUNT_W-1:0] r_idx;
    logic               load;
    logic               final_beat;

    assign load       = i_valid && (!r_out_valid || o_code.ready);
    assign final_beat = (r_idx == i_cmd.count - 1'b1);
    assign o_pop      = load && final_beat;

    assign o_code.valid        = r_out_valid;
    assign o_code.code_byte    = r_byte;
    assign o_code.last_of_item = r_last_item;
    assign o_code.image_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte      <= i_cmd.bytes[r_idx];
            r_last_item <= final_beat;
            r_done      <= final_beat && i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= final_beat ? '0 : r_idx + 1'b1;
            end else if (o_code.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[src/rgb_pixel_stream_encoder.sv]
// RGB pixel stream encoder.
// i_pix (sink): one RGB pixel per beat; last_pixel marks the end of an image.
// o_code (source): one byte of the coded stream per beat; last_of_item flags
//   the final byte caused by a pixel, image_done the final byte of an image.
// A pixel yields zero to five bytes: a pending run byte, then an INDEX, DIFF,
// two-byte LUMA or four-byte RGB code. A pixel that extends a run yields none
// unless it is the last one.
// The first byte of a pixel passes the input stage with index read, then is
// classified into the command queue, then the output register loads it from
// the queue head.
// Throughput: one pixel per cycle while each pixel yields at most one byte
// and the receiver is ready; the output moves one byte per cycle unless
// stalled, so multi-byte codes go out a byte at a time. A four-entry
// command queue between classifier and byte serializer absorbs bursts.
// Reset (synchronous, active low) empties the pipeline and queue, clears the
// run count and the color index valid bits; no clearing pass is needed.
// When the receiver stalls, the output byte holds; the queue fills and then
// i_pix.ready drops until space frees up.
module rgb_pixel_stream_encoder import rpse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpse_pix_if.sink    i_pix,
    rpse_code_if.source o_code
);

    logic q_ready;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd head_cmd;
    logic pop;

    rpse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    rpse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    rpse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_code  (o_code)
    );

endmodule

[src/rpse_checker.sv]
module rpse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last_item,
    input logic       i_out_done
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled output beat changed");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_last_item)
        else $error("image_done without last_of_item");

    a_no_out_without_in: assert property (@(posedge i_clk)
        !i_rst_n ##1 !(i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("output beat with no pixel taken since reset");

endmodule

bind rgb_pixel_stream_encoder rpse_checker u_rpse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_code.valid),
    .i_out_ready     (o_code.ready),
    .i_out_byte      (o_code.code_byte),
    .i_out_last_item (o_code.last_of_item),
    .i_out_done      (o_code.image_done)
);
